// ----- src/ihex_pkg.sv -----
// Shared constants and helpers for the Intel HEX record loader.
// No dependencies; imported by the loader and its checker.
`default_nettype none

package ihex_pkg;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned LIMIT_W = 17;

    localparam logic [LIMIT_W-1:0] MEM_LIMIT_RESET = 17'd61440;
    localparam logic [LIMIT_W-1:0] ADDR_SPACE      = 17'h10000;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_WARN  = 2'd2,
        KIND_SKIP  = 2'd3
    } kind_t;

    typedef enum logic [6:0] {
        PH_START = 7'b0000001,
        PH_COUNT = 7'b0000010,
        PH_ADDR  = 7'b0000100,
        PH_TYPE  = 7'b0001000,
        PH_DATA  = 7'b0010000,
        PH_SKIP  = 7'b0100000,
        PH_DONE  = 7'b1000000
    } phase_t;

    // Anything that is not a hex digit reads as 15
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd15;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            v = c - CH_UPPER_A + 8'd10;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            v = c - CH_LOWER_A + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/intel_hex_record_loader.sv -----
// A result item is in the output register the cycle after its character is taken.
// Throughput: one character per cycle; the record parser updates its state in a single pass.
// The input side stalls only while an unread result sits in the output register.
// Reset (rst_n low, asynchronous) returns to start of line, clears the address, size and
// warning state, empties the output register and sets mem_limit to 61440.
// Depends on ihex_pkg.
`default_nettype none

module intel_hex_record_loader (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    ch,
    input  wire logic                          end_of_stream,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         kind,
    output logic [ihex_pkg::ADDR_W-1:0]        write_addr,
    output logic [7:0]                         write_data,
    output logic [ihex_pkg::LIMIT_W-1:0]       prog_size,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ihex_pkg::LIMIT_W-1:0]  cfg_data
);
    import ihex_pkg::*;

    phase_t             phase_reg,    phase_next;
    logic [1:0]         nib_reg,      nib_next;
    logic [7:0]         bytes_reg,    bytes_next;
    logic [LIMIT_W-1:0] load_reg,     load_next;
    logic [7:0]         rkind_reg,    rkind_next;
    logic [3:0]         upper_reg,    upper_next;
    logic [LIMIT_W-1:0] high_reg,     high_next;
    logic               warned_reg,   warned_next;
    logic [LIMIT_W-1:0] limit_reg;

    logic               out_valid_reg;
    kind_t              kind_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [7:0]         data_reg;
    logic [LIMIT_W-1:0] size_reg;

    logic               in_fire;
    logic               emit;
    kind_t              e_kind;
    logic [ADDR_W-1:0]  e_addr;
    logic [7:0]         e_data;
    logic [3:0]         nib_val;
    logic [7:0]         rk_new;
    logic [7:0]         bytes_dec;
    logic [LIMIT_W-1:0] limit_eff;
    logic [LIMIT_W-1:0] load_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign nib_val   = hex_value(ch);
    assign rk_new    = {rkind_reg[3:0], nib_val};
    assign bytes_dec = bytes_reg - 8'd1;
    assign limit_eff = (limit_reg > ADDR_SPACE) ? ADDR_SPACE : limit_reg;
    assign load_inc  = load_reg + 17'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        nib_next    = nib_reg;
        bytes_next  = bytes_reg;
        load_next   = load_reg;
        rkind_next  = rkind_reg;
        upper_next  = upper_reg;
        high_next   = high_reg;
        warned_next = warned_reg;
        emit        = 1'b0;
        e_kind      = KIND_DONE;
        e_addr      = '0;
        e_data      = '0;

        if (in_fire && phase_reg != PH_DONE) begin
            if (end_of_stream) begin
                phase_next = PH_DONE;
                emit       = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (ch != CH_COLON) begin
                            phase_next = PH_DONE;
                            emit       = 1'b1;
                        end else begin
                            phase_next = PH_COUNT;
                            nib_next   = 2'd0;
                            bytes_next = 8'd0;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (ch == CH_NEWLINE) begin
                            phase_next = PH_START;
                        end
                    end
                    default:
                    begin
                        if (ch == CH_NEWLINE) begin
                            // drop the rest of a broken record
                            phase_next = PH_START;
                        end else begin
                            unique case (phase_reg)
                                PH_COUNT:
                                begin
                                    bytes_next = {bytes_reg[3:0], nib_val};
                                    if (nib_reg >= 2'd1) begin
                                        phase_next = PH_ADDR;
                                        nib_next   = 2'd0;
                                        load_next  = '0;
                                    end else begin
                                        nib_next = nib_reg + 2'd1;
                                    end
                                end
                                PH_ADDR:
                                begin
                                    load_next = {1'b0, load_reg[11:0], nib_val};
                                    if (nib_reg >= 2'd3) begin
                                        phase_next = PH_TYPE;
                                        nib_next   = 2'd0;
                                        rkind_next = 8'd0;
                                    end else begin
                                        nib_next = nib_reg + 2'd1;
                                    end
                                end
                                PH_TYPE:
                                begin
                                    rkind_next = rk_new;
                                    if (nib_reg < 2'd1) begin
                                        nib_next = nib_reg + 2'd1;
                                    end else begin
                                        nib_next = 2'd0;
                                        if (rk_new == REC_DATA) begin
                                            phase_next = (bytes_reg != 8'd0) ? PH_DATA
                                                                             : PH_SKIP;
                                        end else if (rk_new == REC_EOF) begin
                                            phase_next = PH_DONE;
                                            emit       = 1'b1;
                                        end else begin
                                            phase_next = PH_SKIP;
                                            emit       = 1'b1;
                                            e_kind     = KIND_SKIP;
                                        end
                                    end
                                end
                                PH_DATA:
                                begin
                                    if (nib_reg == 2'd0) begin
                                        upper_next = nib_val;
                                        nib_next   = 2'd1;
                                    end else begin
                                        nib_next   = 2'd0;
                                        bytes_next = bytes_dec;
                                        if (bytes_dec == 8'd0) begin
                                            phase_next = PH_SKIP;
                                        end
                                        if (load_reg < limit_eff) begin
                                            load_next = load_inc;
                                            if (load_inc > high_reg) begin
                                                high_next = load_inc;
                                            end
                                            emit   = 1'b1;
                                            e_kind = KIND_WRITE;
                                            e_addr = load_reg[ADDR_W-1:0];
                                            e_data = {upper_reg, nib_val};
                                        end else if (!warned_reg) begin
                                            // warn on the first dropped byte only
                                            warned_next = 1'b1;
                                            emit        = 1'b1;
                                            e_kind      = KIND_WARN;
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_START;
            nib_reg       <= '0;
            bytes_reg     <= '0;
            load_reg      <= '0;
            rkind_reg     <= '0;
            upper_reg     <= '0;
            high_reg      <= '0;
            warned_reg    <= 1'b0;
            limit_reg     <= MEM_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            nib_reg    <= nib_next;
            bytes_reg  <= bytes_next;
            load_reg   <= load_next;
            rkind_reg  <= rkind_next;
            upper_reg  <= upper_next;
            high_reg   <= high_next;
            warned_reg <= warned_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result item until it is taken
    always_ff @(posedge clk)
    begin
        if (emit) begin
            kind_reg <= e_kind;
            addr_reg <= e_addr;
            data_reg <= e_data;
            size_reg <= high_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign write_addr = addr_reg;
    assign write_data = data_reg;
    assign prog_size  = size_reg;

endmodule

`default_nettype wire

// ----- src/ihex_checker.sv -----
// Port-level checks for the Intel HEX record loader, attached by bind.
// Depends on ihex_pkg and the ports of intel_hex_record_loader.
`default_nettype none

module ihex_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [7:0]                    ch,
    input wire logic                          end_of_stream,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [1:0]                    kind,
    input wire logic [ihex_pkg::ADDR_W-1:0]   write_addr,
    input wire logic [7:0]                    write_data,
    input wire logic [ihex_pkg::LIMIT_W-1:0]  prog_size,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic [ihex_pkg::LIMIT_W-1:0]  cfg_data
);
    import ihex_pkg::*;

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(write_addr)
                                    && $stable(write_data) && $stable(prog_size))
        else $error("result item changed while stalled");

    // only writes carry an address and data
    a_nonwrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_WRITE |-> write_addr == '0 && write_data == '0)
        else $error("non-write item carries address or data");

    // size always covers the byte just written
    a_size_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_WRITE |-> {1'b0, write_addr} < prog_size)
        else $error("program size below written address");

    // nothing follows the end of the load
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && kind == KIND_DONE |=> !out_valid)
        else $error("result item after load finished");

    // with no pending result the input side never stalls
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind intel_hex_record_loader ihex_checker u_ihex_checker (.*);

`default_nettype wire
